>>> rtl/core/sphere_frustum_cull_test_macros.svh
// Assertion macros shared by the verification files of the sphere frustum cull test.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SPHERE_FRUSTUM_CULL_TEST_MACROS_SVH
`define SPHERE_FRUSTUM_CULL_TEST_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SFCT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SFCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sfct_pkg.sv
// Shared types, widths and constants for the sphere frustum cull test.
// Used by sfct_plane_eval and sphere_frustum_cull_test; depends on nothing.
`default_nettype none

package sfct_pkg;

  localparam int FRAC_BITS   = 12;
  localparam int CULL_BASE   = -80;
  localparam int COORD_W     = 32;
  localparam int COEF_W      = 16;
  localparam int ROW_W       = 3 * COEF_W;
  localparam int RADIUS_W    = 16;
  localparam int PROD_W      = COORD_W + COEF_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int LIMIT_W     = RADIUS_W + 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = ROW_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [LIMIT_W-1:0] limit_t;
  typedef logic [ROW_W-1:0]          row_t;
  typedef logic [RADIUS_W-1:0]       radius_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PLANE_ROW_A = 3'd0,
    REG_PLANE_ROW_B = 3'd1,
    REG_PLANE_ROW_C = 3'd2,
    REG_CAMERA_X    = 3'd3,
    REG_CAMERA_Y    = 3'd4,
    REG_CAMERA_Z    = 3'd5
  } cfg_reg_t;

  // Load enables for the two pipeline stages held inside each plane unit.
  typedef struct packed {
    logic prod_load;
    logic sum_load;
  } plane_en_t;

  function automatic coef_t row_coef(row_t row, axis_t axis);
    coef_t c;
    case (axis)
      AXIS_X:  c = row[0*COEF_W +: COEF_W];
      AXIS_Y:  c = row[1*COEF_W +: COEF_W];
      AXIS_Z:  c = row[2*COEF_W +: COEF_W];
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sfct_plane_eval.sv
// One frustum plane: three 16x32 products in one stage, their sum in the next.
// Depends on sfct_pkg for types, widths and the fraction bit count.
`default_nettype none

module sfct_plane_eval (
  input  wire                 clk,
  input  sfct_pkg::plane_en_t en,
  input  sfct_pkg::row_t      row,
  input  sfct_pkg::coord_t    dx,
  input  sfct_pkg::coord_t    dy,
  input  sfct_pkg::coord_t    dz,
  output sfct_pkg::coord_t    value
);
  import sfct_pkg::*;

  coef_t cx;
  coef_t cy;
  coef_t cz;
  prod_t prod_x;
  prod_t prod_y;
  prod_t prod_z;
  sum_t  sum;

  assign cx = row_coef(row, AXIS_X);
  assign cy = row_coef(row, AXIS_Y);
  assign cz = row_coef(row, AXIS_Z);

  always_ff @(posedge clk) begin
    if (en.prod_load) begin
      prod_x <= prod_t'(cx) * prod_t'(dx);
      prod_y <= prod_t'(cy) * prod_t'(dy);
      prod_z <= prod_t'(cz) * prod_t'(dz);
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum_load) begin
      sum <= sum_t'(prod_x) + sum_t'(prod_y) + sum_t'(prod_z);
    end
  end

  // Arithmetic shift by the fraction bits, then keep the low 32 bits.
  assign value = sum[FRAC_BITS +: COORD_W];

endmodule

`default_nettype wire

>>> rtl/core/sphere_frustum_cull_test.sv
// Bounding-sphere frustum cull test. Each input transaction carries a world
// point and a sphere radius; each output transaction carries one culled flag,
// set when the point lies more than 80 + radius units outside any of the three
// configured planes. The block is a four-stage pipeline: camera subtraction,
// nine 16x32 multiplies, the per-plane sums, and the threshold compare that
// loads the output register. It takes one transaction per cycle while the
// output is not stalled. Stalls back up stage by stage, so empty stages
// still fill while the output waits. Configuration writes go straight to the
// registers and must only be made while no transaction is in flight.
// Depends on sfct_pkg and sfct_plane_eval.
`default_nettype none

module sphere_frustum_cull_test (
  input  wire                         clk,
  input  wire                         rst,
  // configuration write port
  input  wire                         cfg_write,
  input  wire [sfct_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire [sfct_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  wire                         in_valid,
  output logic                        in_stall,
  input  sfct_pkg::coord_t            point_x,
  input  sfct_pkg::coord_t            point_y,
  input  sfct_pkg::coord_t            point_z,
  input  sfct_pkg::radius_t           sphere_radius,
  // output channel
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic                        culled
);
  import sfct_pkg::*;

  // Configuration registers.
  row_t   plane_row_a;
  row_t   plane_row_b;
  row_t   plane_row_c;
  coord_t camera_x;
  coord_t camera_y;
  coord_t camera_z;

  // Pipeline registers.
  logic   s1_valid;
  coord_t s1_dx;
  coord_t s1_dy;
  coord_t s1_dz;
  limit_t s1_limit;
  logic   s2_valid;
  limit_t s2_limit;
  logic   s3_valid;
  limit_t s3_limit;

  logic      s1_load;
  logic      s2_load;
  logic      s3_load;
  logic      out_load;
  plane_en_t plane_en;
  coord_t    value_a;
  coord_t    value_b;
  coord_t    value_c;
  coord_t    limit_ext;
  logic      keep;

  // Register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_row_a <= '0;
      plane_row_b <= '0;
      plane_row_c <= '0;
      camera_x    <= '0;
      camera_y    <= '0;
      camera_z    <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_PLANE_ROW_A: plane_row_a <= cfg_data[ROW_W-1:0];
        REG_PLANE_ROW_B: plane_row_b <= cfg_data[ROW_W-1:0];
        REG_PLANE_ROW_C: plane_row_c <= cfg_data[ROW_W-1:0];
        REG_CAMERA_X:    camera_x    <= cfg_data[COORD_W-1:0];
        REG_CAMERA_Y:    camera_y    <= cfg_data[COORD_W-1:0];
        REG_CAMERA_Z:    camera_z    <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or when the stage after it loads. The
  // output register frees up as soon as its transaction is taken.
  assign out_load = !out_valid || !out_stall;
  assign s3_load  = !s3_valid || out_load;
  assign s2_load  = !s2_valid || s3_load;
  assign s1_load  = !s1_valid || s2_load;
  assign in_stall = !s1_load;

  assign plane_en.prod_load = s2_load;
  assign plane_en.sum_load  = s3_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= in_valid;
      end
      if (s2_load) begin
        s2_valid <= s1_valid;
      end
      if (s3_load) begin
        s3_valid <= s2_valid;
      end
      if (out_load) begin
        out_valid <= s3_valid;
      end
    end
  end

  // Stage 1: camera-relative position with 32-bit wrap, and the cull limit
  // of -80 minus the radius, which always fits in 18 signed bits.
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_dx    <= point_x - camera_x;
      s1_dy    <= point_y - camera_y;
      s1_dz    <= point_z - camera_z;
      s1_limit <= limit_t'(CULL_BASE) - limit_t'(sphere_radius);
    end
  end

  // The limit rides alongside the plane units through stages 2 and 3.
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_limit <= s1_limit;
    end
    if (s3_load) begin
      s3_limit <= s2_limit;
    end
  end

  sfct_plane_eval u_plane_a (
    .clk   (clk),
    .en    (plane_en),
    .row   (plane_row_a),
    .dx    (s1_dx),
    .dy    (s1_dy),
    .dz    (s1_dz),
    .value (value_a)
  );

  sfct_plane_eval u_plane_b (
    .clk   (clk),
    .en    (plane_en),
    .row   (plane_row_b),
    .dx    (s1_dx),
    .dy    (s1_dy),
    .dz    (s1_dz),
    .value (value_b)
  );

  sfct_plane_eval u_plane_c (
    .clk   (clk),
    .en    (plane_en),
    .row   (plane_row_c),
    .dx    (s1_dx),
    .dy    (s1_dy),
    .dz    (s1_dz),
    .value (value_c)
  );

  // Stage 4: the point is kept only if every plane value reaches the limit.
  assign limit_ext = coord_t'(s3_limit);
  assign keep = (value_a >= limit_ext) && (value_b >= limit_ext) &&
                (value_c >= limit_ext);

  always_ff @(posedge clk) begin
    if (out_load) begin
      culled <= !keep;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sfct_checker.sv
// Port-level checks for the sphere frustum cull test, bound to its top level.
// Depends on sphere_frustum_cull_test_macros.svh for the assertion macros.
`default_nettype none

`include "sphere_frustum_cull_test_macros.svh"

module sfct_checker (
  input wire clk,
  input wire rst,
  input wire in_valid,
  input wire in_stall,
  input wire out_valid,
  input wire out_stall,
  input wire culled
);

  // A stalled result stays put until it is taken.
  `SFCT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(culled), "stalled result changed")

  // With the output draining, every stage moves, so the input never stalls.
  `SFCT_ASSERT_SAME(a_no_stall_when_draining, !out_stall, !in_stall, "input stalled while output drains")

  // An accepted transaction passes through stages 1 to 3 into the output register
  // when the output is not stalled in between.
  `SFCT_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall, out_valid, "result missing after pipeline latency")

endmodule

bind sphere_frustum_cull_test sfct_checker u_sfct_checker (.*);

`default_nettype wire

>>> bench/sphere_frustum_cull_test_tb.sv
// Self-checking bench for sphere_frustum_cull_test: a directed table, then random objects.
// It checks every culled flag against a typed-in value or a predictor of the plane test.
// Depends on sfct_pkg and the sphere_frustum_cull_test RTL only.
`default_nettype none

module sphere_frustum_cull_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfct_pkg::*;

  // Register indexes past the end of the map. Writes to them must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  // Flag values for the directed rows whose answer is typed in.
  localparam logic KEEP = 1'b0;
  localparam logic CULL = 1'b1;

  // Cycles with no transaction on any port before the run is declared hung.
  // The longest legal quiet stretch is a run of random idles at 84 percent,
  // which stays well below this in practice.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_CHUNKS = 10;
  localparam int unsigned CHUNK_POINTS = 50;

  typedef enum logic {STEP_WRITE, STEP_POINT} step_kind_t;

  // One row of the directed table: either a register write or an object.
  // For an object, typed tells whether the expected flag is written in the row
  // or has to come from the predictor.
  typedef struct packed {
    step_kind_t             kind;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    coord_t                 px;
    coord_t                 py;
    coord_t                 pz;
    radius_t                radius;
    logic                   typed;
    logic                   culled;
  } step_t;

  // What the output should carry, plus a sequence tag to find it in a log.
  typedef struct packed {
    logic        culled;
    int unsigned tag;
  } cull_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic    in_valid = 1'b0;
  logic    in_stall;
  coord_t  point_x = '0;
  coord_t  point_y = '0;
  coord_t  point_z = '0;
  radius_t sphere_radius = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic culled;

  // Shadow copy of the block's registers, kept in step with every write.
  row_t   plane_rows [3];
  coord_t view_origin [3];

  cull_entry_t culled_expected [$];
  cull_entry_t head_entry;
  step_t       directed_steps [$];

  int unsigned mismatch_count = 0;
  int unsigned item_tag = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  sphere_frustum_cull_test dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .point_x       (point_x),
    .point_y       (point_y),
    .point_z       (point_z),
    .sphere_radius (sphere_radius),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .culled        (culled)
  );

  always #6 clk = ~clk;

  // The predictor. The point is moved to camera space with 32-bit wrap, each
  // plane row is dotted with it at full width, floored by the fraction bits,
  // and the low 32 bits are compared against minus 80 minus the radius.
  function automatic logic cull_predict(coord_t px, coord_t py, coord_t pz, radius_t r);
    coord_t            delta [3];
    longint            acc;
    longint            floor_v;
    logic signed [31:0] plane_v;
    logic              outside;
    delta[0] = px - view_origin[0];
    delta[1] = py - view_origin[1];
    delta[2] = pz - view_origin[2];
    floor_v = longint'(CULL_BASE) - longint'(r);
    outside = 1'b0;
    for (int p = 0; p < 3; p++) begin
      acc = 0;
      for (int a = 0; a < 3; a++) begin
        acc += longint'(coef_t'(plane_rows[p][a*COEF_W +: COEF_W])) * longint'(delta[a]);
      end
      acc = acc >>> FRAC_BITS;
      plane_v = acc[31:0];
      if (longint'(plane_v) < floor_v) begin
        outside = 1'b1;
      end
    end
    return outside;
  endfunction

  function automatic row_t pack_row(coef_t cx, coef_t cy, coef_t cz);
    return {cz, cy, cx};
  endfunction

  function automatic step_t wr_step(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    step_t s;
    s = '0;
    s.kind = STEP_WRITE;
    s.index = idx;
    s.data = value;
    return s;
  endfunction

  function automatic step_t pt_model(coord_t x, coord_t y, coord_t z, radius_t r);
    step_t s;
    s = '0;
    s.kind = STEP_POINT;
    s.px = x;
    s.py = y;
    s.pz = z;
    s.radius = r;
    return s;
  endfunction

  function automatic step_t pt_known(coord_t x, coord_t y, coord_t z, radius_t r, logic flag);
    step_t s;
    s = pt_model(x, y, z, r);
    s.typed = 1'b1;
    s.culled = flag;
    return s;
  endfunction

  // Coefficients for the random chunks. The first two chunks pin every
  // coefficient to the positive and the negative extreme.
  function automatic coef_t pick_coef(int unsigned chunk);
    coef_t c;
    if (chunk == 0) begin
      c = 16'h7FFF;
    end else if (chunk == 1) begin
      c = 16'h8000;
    end else begin
      case ($urandom_range(3))
        0: c = coef_t'($urandom);
        1: c = coef_t'(int'($urandom_range(16'h2000)) - 16'h1000);
        2: c = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        default: c = '0;
      endcase
    end
    return c;
  endfunction

  function automatic coord_t pick_origin(int unsigned chunk);
    coord_t o;
    if (chunk == 0) begin
      o = 32'h7FFF_FFFF;
    end else if (chunk == 1) begin
      o = 32'h8000_0000;
    end else begin
      case ($urandom_range(3))
        0, 1: o = coord_t'($urandom);
        2: o = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: o = '0;
      endcase
    end
    return o;
  endfunction

  // Writes one register and mirrors it into the shadow copy. The enable is
  // dropped for a cycle so that back-to-back writes never lower and raise it
  // in the same time step.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_PLANE_ROW_A: plane_rows[0] = value;
      REG_PLANE_ROW_B: plane_rows[1] = value;
      REG_PLANE_ROW_C: plane_rows[2] = value;
      REG_CAMERA_X:    view_origin[0] = value[COORD_W-1:0];
      REG_CAMERA_Y:    view_origin[1] = value[COORD_W-1:0];
      REG_CAMERA_Z:    view_origin[2] = value[COORD_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Presents one object, after a random number of idle cycles, and holds it
  // until the block takes it. The expected flag is queued at the edge where
  // the transaction is accepted. While idle the payload carries junk.
  task automatic send_point(coord_t px, coord_t py, coord_t pz, radius_t r,
                            logic typed, logic typed_flag);
    logic want;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      point_x <= coord_t'($urandom);
      point_y <= coord_t'($urandom);
      point_z <= coord_t'($urandom);
      sphere_radius <= radius_t'($urandom);
      @(posedge clk);
    end
    want = typed ? typed_flag : cull_predict(px, py, pz, r);
    in_valid <= 1'b1;
    point_x <= px;
    point_y <= py;
    point_z <= pz;
    sphere_radius <= r;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    culled_expected.push_back(cull_entry_t'{want, item_tag});
    item_tag++;
  endtask

  // Stops sending and waits until every flag in flight has come out. Every
  // object yields exactly one flag, so an empty queue means an empty pipe.
  task automatic settle();
    in_valid <= 1'b0;
    while (culled_expected.size() != 0) begin
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  // The receiver stalls at random with the current percentage.
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Output checker. Each accepted flag is matched against the oldest
  // expectation; a flag with nothing outstanding is itself a failure.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (culled_expected.size() == 0) begin
        $display("%0t: culled=%0b arrived with no transaction outstanding", $time, culled);
        mismatch_count++;
      end else begin
        head_entry = culled_expected.pop_front();
        if (culled !== head_entry.culled) begin
          $display("%0t: transaction %0d culled expected %0b, actual %0b",
                   $time, head_entry.tag, head_entry.culled, culled);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any accepted transaction or register write restarts the count.
  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, culled_expected.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    coord_t  rx;
    coord_t  ry;
    coord_t  rz;
    radius_t rr;

    for (int i = 0; i < 3; i++) begin
      plane_rows[i] = '0;
      view_origin[i] = '0;
    end

    // Directed table. Straight after reset every plane is zero, so every
    // object is kept whatever its coordinates.
    directed_steps.push_back(pt_known(0, 0, 0, 0, KEEP));
    directed_steps.push_back(pt_known(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF, KEEP));
    directed_steps.push_back(pt_known(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, KEEP));
    // A single plane x >= -80 - radius, coefficient 1.0. The rows sit on
    // either side of the threshold for the smallest and largest radius.
    directed_steps.push_back(wr_step(REG_PLANE_ROW_A, pack_row(16'h1000, 0, 0)));
    directed_steps.push_back(pt_known(-80, 0, 0, 0, KEEP));
    directed_steps.push_back(pt_known(-81, 0, 0, 0, CULL));
    directed_steps.push_back(pt_known(-65615, 123, -7, 16'hFFFF, KEEP));
    directed_steps.push_back(pt_known(-65616, 0, 0, 16'hFFFF, CULL));
    // Moving the camera shifts the same threshold by its x position.
    directed_steps.push_back(wr_step(REG_CAMERA_X, 48'd20));
    directed_steps.push_back(pt_known(-60, 0, 0, 0, KEEP));
    directed_steps.push_back(pt_known(-61, 0, 0, 0, CULL));
    // Camera at the most negative x: the difference wraps at 32 bits.
    directed_steps.push_back(wr_step(REG_CAMERA_X, 48'h0000_8000_0000));
    directed_steps.push_back(pt_model(32'h7FFF_FFFF, 0, 0, 0));
    directed_steps.push_back(pt_model(0, 0, 0, 0));
    // The other two rows and camera axes; junk above bit 31 of a camera
    // write has to be dropped.
    directed_steps.push_back(wr_step(REG_PLANE_ROW_B, pack_row(0, 16'hF000, 0)));
    directed_steps.push_back(wr_step(REG_PLANE_ROW_C, pack_row(0, 0, 16'h7FFF)));
    directed_steps.push_back(wr_step(REG_CAMERA_Y, 48'hABCD_FFFF_FFFF));
    directed_steps.push_back(wr_step(REG_CAMERA_Z, 48'h1234_0000_0010));
    directed_steps.push_back(pt_model(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 100));
    directed_steps.push_back(pt_model(-5, 1000, -1000, 0));
    // Every coefficient at -8.0 and the point at the most negative corner:
    // each sum is 3 * 2^46, which after the shift has all-zero low bits.
    directed_steps.push_back(wr_step(REG_PLANE_ROW_A, pack_row(16'h8000, 16'h8000, 16'h8000)));
    directed_steps.push_back(wr_step(REG_PLANE_ROW_B, pack_row(16'h8000, 16'h8000, 16'h8000)));
    directed_steps.push_back(wr_step(REG_PLANE_ROW_C, pack_row(16'h8000, 16'h8000, 16'h8000)));
    directed_steps.push_back(wr_step(REG_CAMERA_X, 48'd0));
    directed_steps.push_back(wr_step(REG_CAMERA_Y, 48'd0));
    directed_steps.push_back(wr_step(REG_CAMERA_Z, 48'd0));
    directed_steps.push_back(pt_known(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, KEEP));
    directed_steps.push_back(pt_model(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    directed_steps.push_back(wr_step(REG_PLANE_ROW_A, pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF)));
    directed_steps.push_back(wr_step(REG_PLANE_ROW_B, pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF)));
    directed_steps.push_back(wr_step(REG_PLANE_ROW_C, pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF)));
    directed_steps.push_back(pt_model(32'h8000_0000, 32'h7FFF_FFFF, 1, 16'hFFFF));
    directed_steps.push_back(pt_model(12345, -12345, 0, 40));
    // Indexes past the register map are ignored by the block.
    directed_steps.push_back(wr_step(REG_UNMAPPED_LO, '1));
    directed_steps.push_back(wr_step(REG_UNMAPPED_HI, '1));
    directed_steps.push_back(pt_model(-1, -1, -1, 0));
    directed_steps.push_back(pt_model(-300000, 250000, 7, 65000));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // First idling mix: sender idles often, receiver stalls most of the time.
    send_idle_pct = 36;
    recv_stall_pct = 84;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_WRITE) begin
        settle();
        write_reg(directed_steps[i].index, directed_steps[i].data);
      end else begin
        send_point(directed_steps[i].px, directed_steps[i].py, directed_steps[i].pz,
                   directed_steps[i].radius, directed_steps[i].typed,
                   directed_steps[i].culled);
      end
    end

    // Random part in chunks. Each chunk runs under its own register setting,
    // written only once the pipe is empty. The idling mix swaps after four
    // chunks and is switched off for the last three.
    for (int unsigned chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      if (chunk == 4) begin
        send_idle_pct = 84;
        recv_stall_pct = 36;
      end else if (chunk == 7) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end

      settle();
      write_reg(REG_PLANE_ROW_A, pack_row(pick_coef(chunk), pick_coef(chunk), pick_coef(chunk)));
      write_reg(REG_PLANE_ROW_B, pack_row(pick_coef(chunk), pick_coef(chunk), pick_coef(chunk)));
      write_reg(REG_PLANE_ROW_C, pack_row(pick_coef(chunk), pick_coef(chunk), pick_coef(chunk)));
      write_reg(REG_CAMERA_X, {16'($urandom), pick_origin(chunk)});
      write_reg(REG_CAMERA_Y, {16'($urandom), pick_origin(chunk)});
      write_reg(REG_CAMERA_Z, {16'($urandom), pick_origin(chunk)});

      for (int unsigned n = 0; n < CHUNK_POINTS; n++) begin
        // Most objects sit near the camera, at offsets of random magnitude,
        // so that plane values land on both sides of the threshold. The rest
        // are anywhere in the world and are mostly culled.
        if ($urandom_range(3) != 0) begin
          rx = view_origin[0] + coord_t'(int'($urandom) >>> $urandom_range(8, 31));
          ry = view_origin[1] + coord_t'(int'($urandom) >>> $urandom_range(8, 31));
          rz = view_origin[2] + coord_t'(int'($urandom) >>> $urandom_range(8, 31));
        end else begin
          rx = coord_t'($urandom);
          ry = coord_t'($urandom);
          rz = coord_t'($urandom);
        end
        rr = $urandom_range(1) ? radius_t'($urandom) : radius_t'($urandom_range(200));

        // Once in a while the sender holds off until the pipe has drained.
        if (n == CHUNK_POINTS / 2 && chunk % 3 == 2) begin
          settle();
        end
        send_point(rx, ry, rz, rr, 1'b0, 1'b0);
      end
    end

    // Drain, then leave a few cycles for any stray flag to show up.
    settle();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
